// File: design/isrt_pkg.sv
// Package for the insertion sorter: the shared types and fixed widths.
// It has no dependencies. The controller, the datapath and the top level use it.
package isrt_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;     // insert the input value, or drop it when the store is full
    logic shift_out;  // advance the store by one entry toward cell 0
    logic clear;      // end of sequence: clear the fill count and the overflow flag
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic one_left;
  } status_t;

endpackage

// File: design/insertion_sorter_core.sv
// Top level of the insertion sorter: the controller and the datapath joined.
// Depends on isrt_pkg, isrt_ctrl and isrt_datapath.
//
// Stable ascending sorter of signed 32-bit values. Each input transfer is
// inserted into a row of MAX_ITEMS sorted cells: every cell
// compares itself with the new value in parallel and the cells above the
// insertion point shift up by one, so equal values keep their arrival order.
// While collecting, the block takes one item per cycle. The transfer that
// carries last_item_i ends the sequence: after it the block emits the n
// stored values, lowest first, one per cycle while out_ready_i is high, by
// shifting the row down through cell 0, which drives sorted_value_o. The
// in_ready_o output stays low from the final item until the last result has
// been transferred. Items that arrive while the row is full are dropped;
// every result of that sequence then has overflow_o set. last_result_o marks
// the final result.
module insertion_sorter_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [isrt_pkg::DATA_W-1:0]  value_i,
  input  logic                                last_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [isrt_pkg::DATA_W-1:0]  sorted_value_o,
  output logic                                last_result_o,
  output logic                                overflow_o
);

  isrt_pkg::cmd_t    cmd;
  isrt_pkg::status_t status;

  // Sequence the collect and emit phases.
  isrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Hold the sorted row; cell 0 is always the next result.
  isrt_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .status_o   (status),
    .head_o     (sorted_value_o),
    .overflow_o (overflow_o)
  );

  // The final result is the one emitted while a single entry remains.
  assign last_result_o = status.one_left;

endmodule

// File: design/isrt_ctrl.sv
// Sequencer for the insertion sorter: it collects items, then emits results.
// Depends on isrt_pkg.
module isrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_item_i,
  input  logic              out_ready_i,
  input  isrt_pkg::status_t status_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output isrt_pkg::cmd_t    cmd_o
);

  isrt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isrt_pkg::ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      isrt_pkg::ST_COLLECT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.insert = 1'b1;
          if (last_item_i) begin
            state_d = isrt_pkg::ST_EMIT;
          end
        end
      end
      isrt_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.shift_out = 1'b1;
          if (status_i.one_left) begin
            cmd_o.clear = 1'b1;
            state_d     = isrt_pkg::ST_COLLECT;
          end
        end
      end
      default: begin
        state_d = isrt_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

// File: design/isrt_datapath.sv
// Datapath of the insertion sorter: a row of sorted cells with a parallel
// compare-and-shift, the fill count and the overflow flag. Depends on isrt_pkg.
module isrt_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isrt_pkg::cmd_t                      cmd_i,
  input  logic signed [isrt_pkg::DATA_W-1:0]  value_i,
  output isrt_pkg::status_t                   status_o,
  output logic signed [isrt_pkg::DATA_W-1:0]  head_o,
  output logic                                overflow_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic signed [isrt_pkg::DATA_W-1:0] cell_q [MAX_ITEMS];
  logic signed [isrt_pkg::DATA_W-1:0] cell_d [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]               gt;
  logic [CNT_W-1:0]                   count_q, count_d;
  logic                               drop_q, drop_d;
  logic                               full;

  assign full = (count_q == CNT_W'(MAX_ITEMS));

  // Cells at or past the fill count act as greater, so a value lands at the
  // first cell holding a strictly greater value (stable order).
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= count_q) || (cell_q[i] > value_i);

    always_comb begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert && !full && gt[i]) begin
        if (i == 0) begin
          cell_d[i] = value_i;
        end else if (gt[(i == 0) ? 0 : i - 1]) begin
          cell_d[i] = cell_q[(i == 0) ? 0 : i - 1];
        end else begin
          cell_d[i] = value_i;
        end
      end else if (cmd_i.shift_out && (i < MAX_ITEMS - 1)) begin
        cell_d[i] = cell_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (cmd_i.insert) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.shift_out) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  assign status_o.one_left = (count_q == CNT_W'(1));
  assign head_o            = cell_q[0];
  assign overflow_o        = drop_q;

endmodule
